// ===== rtl/gpms_pkg.sv =====
// Shared types and constants for the grid path max-sum block.
package gpms_pkg;

    // Grid and value geometry
    localparam int MAX_COLS    = 1024;
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int MAX_SKIPS   = 2;
    localparam int NUM_LANES   = MAX_SKIPS + 1;
    localparam int VALUE_BITS  = 16;
    localparam int SUM_W       = 32;
    localparam int LINE_W      = NUM_LANES * SUM_W;
    localparam int SKIP_W      = 2;

    // Cell queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam logic REG_SKIP_LIMIT = 1'b0;   // word index of skip_limit
    localparam logic [SKIP_W-1:0] SKIP_LIMIT_RST = SKIP_W'(2);

    // Saturation bounds
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef t_sum [NUM_LANES-1:0]    t_line;

    // One classified cell handed from front to back
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         grid_end;
        logic [COL_BITS-1:0]          col;
        logic                         first_row;
        logic                         col_zero;
    } t_cell;

endpackage

// ===== rtl/gpms_front.sv =====
// Front end: accepts cell beats, tracks row/column position, classifies cells.
module gpms_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gpms_pkg::VALUE_BITS-1:0] i_value,
    input  logic                           i_row_end,
    input  logic                           i_grid_end,
    input  logic                           i_q_ready,
    output logic                           o_q_push,
    output gpms_pkg::t_cell                o_q_cell
);
    import gpms_pkg::*;

    logic [COL_BITS-1:0] r_col, n_col;
    logic                r_first, n_first;
    logic                accept;

    assign s_tready = i_q_ready;
    assign accept   = s_tvalid & i_q_ready;
    assign o_q_push = accept;

    // Classify the incoming cell by its grid position
    always_comb begin
        o_q_cell.value     = $signed(i_value);
        o_q_cell.grid_end  = i_grid_end;
        o_q_cell.col       = r_col;
        o_q_cell.first_row = r_first;
        o_q_cell.col_zero  = (r_col == '0);
    end

    // Advance position: grid end restarts, row end wraps, long rows saturate
    always_comb begin
        n_col   = r_col;
        n_first = r_first;
        if (accept) begin
            priority if (i_grid_end) begin
                n_col   = '0;
                n_first = 1'b1;
            end else if (i_row_end) begin
                n_col   = '0;
                n_first = 1'b0;
            end else if (r_col != COL_BITS'(MAX_COLS - 1)) begin
                n_col   = r_col + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
        end else begin
            r_col   <= n_col;
            r_first <= n_first;
        end
    end

endmodule

// ===== rtl/gpms_queue.sv =====
// Short cell queue that decouples the front end from the DP back end.
module gpms_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gpms_pkg::t_cell i_cell,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output gpms_pkg::t_cell o_cell
);
    import gpms_pkg::*;

    t_cell             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cell  = r_slot[r_rp];

    // Store pushed cells
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cell;
        end
    end

    // Move pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/gpms_back.sv =====
// Back end: column line memory, per-skip DP update and result register.
module gpms_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  gpms_pkg::t_cell               i_q_cell,
    output logic                          o_q_pop,
    input  logic [gpms_pkg::SKIP_W-1:0]   i_skip_limit,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gpms_pkg::SUM_W-1:0]    o_best_total
);
    import gpms_pkg::*;

    logic [LINE_W-1:0]   r_mem [MAX_COLS];
    t_line               r_rdata;
    t_line               r_left;
    t_cell               r_s1;
    logic                r_s1_vld;
    logic                r_out_vld;
    logic [SUM_W-1:0]    r_out_data;

    logic                s1_done;
    logic [COL_BITS-1:0] rd_addr;
    t_line               prev;
    t_line               cur;
    logic signed [SUM_W:0] sum;
    logic signed [SUM_W-1:0] vext;
    logic [SKIP_W-1:0]   sel;

    // Stage one completes unless its result would overrun a held output
    assign s1_done = r_s1_vld & (~r_s1.grid_end | ~r_out_vld | m_tready);
    assign o_q_pop = i_q_valid & (~r_s1_vld | s1_done);
    // Re-read the held cell's entry while stalled
    assign rd_addr = o_q_pop ? i_q_cell.col : r_s1.col;

    // Line memory write
    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            r_mem[r_s1.col] <= cur;
        end
    end

    // Registered read with write-first bypass for back-to-back same column
    always_ff @(posedge i_clk) begin
        if (s1_done && (r_s1.col == rd_addr)) begin
            r_rdata <= cur;
        end else begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // DP update for every skip count
    always_comb begin
        vext = SUM_W'(r_s1.value);
        for (int k = 0; k < NUM_LANES; k++) begin
            priority if (r_s1.first_row && r_s1.col_zero) begin
                prev[k] = '0;
            end else if (r_s1.first_row) begin
                prev[k] = r_left[k];
            end else if (r_s1.col_zero) begin
                prev[k] = r_rdata[k];
            end else begin
                prev[k] = (r_rdata[k] > r_left[k]) ? r_rdata[k] : r_left[k];
            end
        end
        for (int k = 0; k < NUM_LANES; k++) begin
            sum = (SUM_W+1)'(prev[k]) + (SUM_W+1)'(vext);
            if (sum[SUM_W] != sum[SUM_W-1]) begin
                cur[k] = sum[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
                cur[k] = sum[SUM_W-1:0];
            end
            // Skip a negative cell by carrying the lower skip count's sum
            if (k > 0 && vext < 0 && prev[k-1] > cur[k]) begin
                cur[k] = prev[k-1];
            end
        end
    end

    // Clamp the skip selector to the lanes present
    assign sel = (i_skip_limit > SKIP_W'(MAX_SKIPS)) ? SKIP_W'(MAX_SKIPS) : i_skip_limit;

    // Stage-one payload and result register
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1 <= i_q_cell;
        end
        if (s1_done && r_s1.grid_end) begin
            r_out_data <= cur[sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_left    <= '0;
        end else begin
            if (o_q_pop) begin
                r_s1_vld <= 1'b1;
            end else if (s1_done) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_done) begin
                r_left <= cur;
            end
            if (s1_done && r_s1.grid_end) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign m_tvalid     = r_out_vld;
    assign o_best_total = r_out_data;

endmodule

// ===== rtl/grid_path_max_sum_with_skips.sv =====
// Top level of the grid path max-sum block with negative-cell skips.
// Cells stream in raster order, one beat per cell, s_tlast closing each row and s_tuser marking
// the bottom-right cell. The block sustains one cell per clock: the front tracks the column and
// row, a two-entry queue feeds the back, whose line memory (one entry of three 32-bit sums per
// column, up to 1024 columns) is read as a cell leaves the queue and written as it completes.
// A cell passes from its accepted beat through the queue slot and the stage-one register before
// its DP update and line write; the best total for the chosen skip_limit is registered on m_tdata
// together with the grid-end cell's line write, and it is held until taken.
// The input stalls only while a finished total still waits on m_tready and the next grid-end
// cell reaches the back end; the queue then takes the beats behind it and s_tready drops once
// it is full. A row longer than 1024 cells keeps reusing the last column entry. No clearing
// pass follows reset; a cell below a column never written since reset gives an undefined total.
module grid_path_max_sum_with_skips (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Cell stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] cell_value
    input  logic        s_tlast,    // row_end
    input  logic        s_tuser,    // [0] grid_end
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] best_total
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [gpms_pkg::APB_AW-1:0] paddr,
    input  logic [gpms_pkg::APB_DW-1:0] pwdata,
    output logic [gpms_pkg::APB_DW-1:0] prdata,
    output logic        pready
);
    import gpms_pkg::*;

    logic              q_ready, q_push, q_valid, q_pop;
    t_cell             push_cell, head_cell;
    logic [SKIP_W-1:0] r_skip_limit;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_limit <= SKIP_LIMIT_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SKIP_LIMIT)) begin
            r_skip_limit <= pwdata[SKIP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SKIP_LIMIT) ? APB_DW'(r_skip_limit) : '0;

    gpms_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .i_value    (s_tdata[VALUE_BITS-1:0]),
        .i_row_end  (s_tlast),
        .i_grid_end (s_tuser),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_cell   (push_cell)
    );

    gpms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cell  (push_cell),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cell  (head_cell)
    );

    gpms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cell     (head_cell),
        .o_q_pop      (q_pop),
        .i_skip_limit (r_skip_limit),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .o_best_total (m_tdata)
    );

endmodule
